/* rtl/ntc_pkg.sv */
// Package for the NTC thermistor Beta-equation temperature converter.
// Holds field widths, register indexes, reset values and fixed-point constants.
// Depends on nothing; every rtl file refers to it by scoped names.
package ntc_pkg;

   localparam int CODE_W      = 12;
   localparam int OHMS_W      = 24;
   localparam int KELVIN_W    = 16;
   localparam int TEMP_W      = 17;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 24;

   localparam int ADC_FULL_SCALE_DEFAULT = 4095;

   // Fixed point: Q30 logarithms and reciprocals.
   localparam int FRAC_W    = 30;
   localparam int MANT_W    = FRAC_W + 1;
   localparam int LOG_IN_W  = OHMS_W + CODE_W;
   localparam int LOG_TOP_W = $clog2(LOG_IN_W);
   localparam int LOG_W     = LOG_TOP_W + FRAC_W;
   localparam int LOG_LANES = 3;

   localparam int DMAG_W      = 36;
   localparam int DMAG_HALF_W = DMAG_W / 2;
   localparam int LN2_W       = 26;
   localparam logic [LN2_W-1:0] LN2_Q26 = 26'd46516320;

   localparam int DIV_NUM_W = 38;
   localparam logic [DIV_NUM_W-1:0] CENTI_ONE_Q30 = 38'd100 << FRAC_W;

   localparam logic [DIV_NUM_W-1:0] KELVIN_OFFSET_CENTI = 38'd27315;
   localparam logic [DIV_NUM_W-1:0] TK_LIMIT            = 38'd92850;
   localparam logic signed [TEMP_W-1:0] TEMP_MAX        = 17'sd65535;
   localparam logic signed [TEMP_W-1:0] TEMP_MIN        = -17'sd27315;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_PULLUP_OHMS   = 3'd0,
      CSR_NOMINAL_OHMS  = 3'd1,
      CSR_BETA_KELVIN   = 3'd2,
      CSR_NOMINAL_CK    = 3'd3,
      CSR_LOW_LIMIT     = 3'd4,
      CSR_HIGH_LIMIT    = 3'd5
   } csr_index_type;

   localparam logic [OHMS_W-1:0]   PULLUP_RESET  = 24'd100000;
   localparam logic [OHMS_W-1:0]   NOMINAL_RESET = 24'd10000;
   localparam logic [KELVIN_W-1:0] BETA_RESET    = 16'd3950;
   localparam logic [KELVIN_W-1:0] T0_RESET      = 16'd29815;
   localparam logic [CODE_W-1:0]   LOW_RESET     = 12'd50;
   localparam logic [CODE_W-1:0]   HIGH_RESET    = 12'd4000;

   // Per-beat status that travels down the pipeline with the data.
   typedef struct packed {
      logic out_of_range;
      logic saturate;
      logic negative;
   } flags_type;

endpackage

/* rtl/ntc_beta_temperature_convert.sv */
// Top level of the NTC thermistor converter: ADC code in, hundredths of a degree C out.
// Uses ntc_pkg, ntc_log2_pipe and ntc_div_pipe.
//
//   Channel   Ports                                       Direction
//   req       req_valid, req_ready, req_adc_code          in
//   rsp       rsp_valid, rsp_ready, rsp_temp_centi_celsius, rsp_out_of_range   out
//   csr       csr_wr_en, csr_index, csr_wdata             in (write only)
//
// One beat enters per cycle while req_ready is high.
// Each beat passes through the 32-stage logarithm and the two 38-stage dividers in series.
// Reset is synchronous and clears the valid bits and the registers to their defaults.
// The whole pipeline holds while a result waits in the output register; req_ready is
// low exactly then, so a stall drops and repeats nothing.
module ntc_beta_temperature_convert #(
   parameter int ADC_FULL_SCALE = ntc_pkg::ADC_FULL_SCALE_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  logic [ntc_pkg::CODE_W-1:0] req_adc_code,
   output logic rsp_valid,
   input  logic rsp_ready,
   output logic signed [ntc_pkg::TEMP_W-1:0] rsp_temp_centi_celsius,
   output logic rsp_out_of_range,
   input  logic csr_wr_en,
   input  logic [ntc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ntc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   localparam int CODE_W   = ntc_pkg::CODE_W;
   localparam int DEN_W    = $clog2(ADC_FULL_SCALE + 1);
   localparam int CMP_W    = (DEN_W > CODE_W) ? DEN_W : CODE_W;
   localparam int LOG_IN_W = ntc_pkg::LOG_IN_W;
   localparam int LOG_W    = ntc_pkg::LOG_W;
   localparam int DMAG_W   = ntc_pkg::DMAG_W;
   localparam int HALF_W   = ntc_pkg::DMAG_HALF_W;
   localparam int PP_W     = HALF_W + ntc_pkg::LN2_W;
   localparam int SUM_W    = DMAG_W + ntc_pkg::LN2_W;
   localparam int NUM_W    = ntc_pkg::DIV_NUM_W;
   localparam int KW       = ntc_pkg::KELVIN_W;
   localparam logic [CMP_W-1:0] FULL_SCALE = CMP_W'(ADC_FULL_SCALE);

   // Configuration registers.
   logic [ntc_pkg::OHMS_W-1:0] pullup_ff;
   logic [ntc_pkg::OHMS_W-1:0] nominal_ff;
   logic [KW-1:0]              beta_ff;
   logic [KW-1:0]              t0_ff;
   logic [CODE_W-1:0]          low_ff;
   logic [CODE_W-1:0]          high_ff;

   logic [ntc_pkg::OHMS_W-1:0] pullup_nz;
   logic [ntc_pkg::OHMS_W-1:0] nominal_nz;
   logic [KW-1:0]              beta_nz;
   logic [KW-1:0]              t0_nz;

   logic advance;

   // Front stage.
   logic                  s0_valid_ff;
   ntc_pkg::flags_type    s0_flags_ff;
   logic [LOG_IN_W-1:0]   s0_prod_ff;
   logic [DEN_W-1:0]      s0_den_ff;
   ntc_pkg::flags_type    s0_flags_in;
   logic [LOG_IN_W-1:0]   s0_prod_in;
   logic [DEN_W-1:0]      s0_den_in;
   logic [CMP_W-1:0]      code_ext;

   // Logarithms.
   logic [ntc_pkg::LOG_LANES-1:0][LOG_IN_W-1:0] log_x;
   logic [ntc_pkg::LOG_LANES-1:0][LOG_W-1:0]    log_val;
   logic                  log_valid;
   ntc_pkg::flags_type    log_flags;

   // Difference of logs, then scaling by ln 2.
   logic                  d_valid_ff;
   ntc_pkg::flags_type    d_flags_ff;
   logic [DMAG_W-1:0]     d_dmag_ff;
   ntc_pkg::flags_type    d_flags_in;
   logic [DMAG_W-1:0]     d_dmag_in;

   logic                  m1_valid_ff;
   ntc_pkg::flags_type    m1_flags_ff;
   logic [PP_W-1:0]       m1_lo_ff;
   logic [PP_W-1:0]       m1_hi_ff;

   logic                  m2_valid_ff;
   ntc_pkg::flags_type    m2_flags_ff;
   logic [NUM_W-1:0]      m2_num_ff;
   logic [NUM_W-1:0]      m2_num_in;

   // Division by beta and reciprocal of T0.
   logic [1:0][NUM_W-1:0] div1_num;
   logic [1:0][KW-1:0]    div1_den;
   logic [1:0][NUM_W-1:0] div1_quo;
   logic                  div1_valid;
   ntc_pkg::flags_type    div1_flags;

   logic                  c_valid_ff;
   ntc_pkg::flags_type    c_flags_ff;
   logic [NUM_W-1:0]      c_inv_ff;
   ntc_pkg::flags_type    c_flags_in;
   logic [NUM_W-1:0]      c_inv_in;

   logic                  c2_valid_ff;
   ntc_pkg::flags_type    c2_flags_ff;
   logic [NUM_W-1:0]      c2_num_ff;
   logic [NUM_W-1:0]      c2_den_ff;

   // Final reciprocal to centikelvin.
   logic [0:0][NUM_W-1:0] div2_quo;
   logic                  div2_valid;
   ntc_pkg::flags_type    div2_flags;

   logic                                 rsp_valid_ff;
   logic signed [ntc_pkg::TEMP_W-1:0]    rsp_temp_ff;
   logic                                 rsp_oor_ff;
   logic signed [ntc_pkg::TEMP_W-1:0]    rsp_temp_in;

   // ---------------------------------------------------------------- registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pullup_ff  <= ntc_pkg::PULLUP_RESET;
         nominal_ff <= ntc_pkg::NOMINAL_RESET;
         beta_ff    <= ntc_pkg::BETA_RESET;
         t0_ff      <= ntc_pkg::T0_RESET;
         low_ff     <= ntc_pkg::LOW_RESET;
         high_ff    <= ntc_pkg::HIGH_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            ntc_pkg::CSR_PULLUP_OHMS:  pullup_ff  <= csr_wdata;
            ntc_pkg::CSR_NOMINAL_OHMS: nominal_ff <= csr_wdata;
            ntc_pkg::CSR_BETA_KELVIN:  beta_ff    <= csr_wdata[KW-1:0];
            ntc_pkg::CSR_NOMINAL_CK:   t0_ff      <= csr_wdata[KW-1:0];
            ntc_pkg::CSR_LOW_LIMIT:    low_ff     <= csr_wdata[CODE_W-1:0];
            ntc_pkg::CSR_HIGH_LIMIT:   high_ff    <= csr_wdata[CODE_W-1:0];
            default: ;
         endcase
      end
   end

   // A resistance, beta or T0 register written as zero behaves as one.
   assign pullup_nz  = (pullup_ff == '0)  ? ntc_pkg::OHMS_W'(1) : pullup_ff;
   assign nominal_nz = (nominal_ff == '0) ? ntc_pkg::OHMS_W'(1) : nominal_ff;
   assign beta_nz    = (beta_ff == '0)    ? KW'(1) : beta_ff;
   assign t0_nz      = (t0_ff == '0)      ? KW'(1) : t0_ff;

   assign advance   = !rsp_valid_ff || rsp_ready;
   assign req_ready = advance;

   // ---------------------------------------------------------------- front stage
   always_comb begin
      code_ext                 = CMP_W'(req_adc_code);
      s0_flags_in.out_of_range = (req_adc_code <= low_ff) || (req_adc_code >= high_ff)
                                 || (code_ext >= FULL_SCALE);
      s0_flags_in.saturate     = (req_adc_code == '0);
      s0_flags_in.negative     = 1'b0;
      s0_prod_in               = LOG_IN_W'(pullup_nz) * LOG_IN_W'(req_adc_code);
      s0_den_in                = DEN_W'(FULL_SCALE - code_ext);
   end

   assign log_x[0] = s0_prod_ff;
   assign log_x[1] = LOG_IN_W'(s0_den_ff);
   assign log_x[2] = LOG_IN_W'(nominal_nz);

   ntc_log2_pipe u_log2 (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (s0_valid_ff),
      .in_x      (log_x),
      .in_flags  (s0_flags_ff),
      .out_valid (log_valid),
      .out_log   (log_val),
      .out_flags (log_flags)
   );

   // ---------------------------------------------------------------- ln(R / R0)
   always_comb begin
      logic [LOG_W:0] a_ext;
      logic [LOG_W:0] b_sum;
      logic [LOG_W:0] diff;
      a_ext      = {1'b0, log_val[0]};
      b_sum      = {1'b0, log_val[1]} + {1'b0, log_val[2]};
      d_flags_in = log_flags;
      d_flags_in.negative = (a_ext < b_sum);
      diff       = d_flags_in.negative ? (b_sum - a_ext) : (a_ext - b_sum);
      d_dmag_in  = DMAG_W'(diff);
   end

   // ln 2 scaling in two partial products; rounding and beta/2 fold into one sum.
   always_comb begin
      logic [SUM_W-1:0] sum;
      sum = {m1_hi_ff, HALF_W'(0)} + SUM_W'(m1_lo_ff)
            + (SUM_W'(1) << (ntc_pkg::LN2_W - 1))
            + (SUM_W'(beta_nz >> 1) << ntc_pkg::LN2_W);
      m2_num_in = NUM_W'(sum >> ntc_pkg::LN2_W);
   end

   assign div1_num[0] = m2_num_ff;
   assign div1_den[0] = beta_nz;
   assign div1_num[1] = ntc_pkg::CENTI_ONE_Q30 + NUM_W'(t0_nz >> 1);
   assign div1_den[1] = t0_nz;

   ntc_div_pipe #(
      .LANES (2),
      .DW    (KW)
   ) u_div_beta (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (m2_valid_ff),
      .in_num    (div1_num),
      .in_den    (div1_den),
      .in_flags  (m2_flags_ff),
      .out_valid (div1_valid),
      .out_quo   (div1_quo),
      .out_flags (div1_flags)
   );

   // ---------------------------------------------------------------- 1/T
   always_comb begin
      logic hot;
      hot        = div1_flags.negative && (div1_quo[0] >= div1_quo[1]);
      c_flags_in = div1_flags;
      c_flags_in.saturate = div1_flags.saturate || hot;
      c_inv_in   = div1_flags.negative ? (div1_quo[1] - div1_quo[0])
                                       : (div1_quo[1] + div1_quo[0]);
   end

   ntc_div_pipe #(
      .LANES (1),
      .DW    (NUM_W)
   ) u_div_recip (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (c2_valid_ff),
      .in_num    (c2_num_ff),
      .in_den    (c2_den_ff),
      .in_flags  (c2_flags_ff),
      .out_valid (div2_valid),
      .out_quo   (div2_quo),
      .out_flags (div2_flags)
   );

   // ---------------------------------------------------------------- result
   always_comb begin
      if (div2_flags.out_of_range) begin
         rsp_temp_in = '0;
      end else if (div2_flags.saturate || (div2_quo[0] > ntc_pkg::TK_LIMIT)) begin
         rsp_temp_in = ntc_pkg::TEMP_MAX;
      end else begin
         rsp_temp_in = ntc_pkg::TEMP_W'(div2_quo[0] - ntc_pkg::KELVIN_OFFSET_CENTI);
      end
   end

   // ---------------------------------------------------------------- pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff  <= 1'b0;
         d_valid_ff   <= 1'b0;
         m1_valid_ff  <= 1'b0;
         m2_valid_ff  <= 1'b0;
         c_valid_ff   <= 1'b0;
         c2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         s0_valid_ff  <= req_valid;
         d_valid_ff   <= log_valid;
         m1_valid_ff  <= d_valid_ff;
         m2_valid_ff  <= m1_valid_ff;
         c_valid_ff   <= div1_valid;
         c2_valid_ff  <= c_valid_ff;
         rsp_valid_ff <= div2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s0_flags_ff <= s0_flags_in;
         s0_prod_ff  <= s0_prod_in;
         s0_den_ff   <= s0_den_in;
         d_flags_ff  <= d_flags_in;
         d_dmag_ff   <= d_dmag_in;
         m1_flags_ff <= d_flags_ff;
         m1_lo_ff    <= PP_W'(d_dmag_ff[HALF_W-1:0]) * PP_W'(ntc_pkg::LN2_Q26);
         m1_hi_ff    <= PP_W'(d_dmag_ff[DMAG_W-1:HALF_W]) * PP_W'(ntc_pkg::LN2_Q26);
         m2_flags_ff <= m1_flags_ff;
         m2_num_ff   <= m2_num_in;
         c_flags_ff  <= c_flags_in;
         c_inv_ff    <= c_inv_in;
         c2_flags_ff <= c_flags_ff;
         c2_num_ff   <= ntc_pkg::CENTI_ONE_Q30 + (c_inv_ff >> 1);
         c2_den_ff   <= c_inv_ff;
         rsp_temp_ff <= rsp_temp_in;
         rsp_oor_ff  <= div2_flags.out_of_range;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_temp_centi_celsius = rsp_temp_ff;
   assign rsp_out_of_range       = rsp_oor_ff;

   // ---------------------------------------------------------------- checks
   a_temp_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_temp_centi_celsius >= ntc_pkg::TEMP_MIN))
      else $error("temperature below absolute zero");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_range) |-> (rsp_temp_centi_celsius == '0))
      else $error("out-of-range beat carries a temperature");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      !advance |=> ($stable(s0_valid_ff) && $stable(m2_valid_ff) && $stable(c2_valid_ff)))
      else $error("pipeline moved during a stall");

endmodule

/* rtl/ntc_log2_pipe.sv */
// Pipelined base-2 logarithm in Q30 for three lanes sharing one beat.
// Leading-one detect, normalize, then one squaring step per stage.
// Depends on ntc_pkg.
module ntc_log2_pipe (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic in_valid,
   input  logic [ntc_pkg::LOG_LANES-1:0][ntc_pkg::LOG_IN_W-1:0] in_x,
   input  ntc_pkg::flags_type in_flags,
   output logic out_valid,
   output logic [ntc_pkg::LOG_LANES-1:0][ntc_pkg::LOG_W-1:0] out_log,
   output ntc_pkg::flags_type out_flags
);

   localparam int L      = ntc_pkg::LOG_LANES;
   localparam int IN_W   = ntc_pkg::LOG_IN_W;
   localparam int TOP_W  = ntc_pkg::LOG_TOP_W;
   localparam int MANT_W = ntc_pkg::MANT_W;
   localparam int FRAC_W = ntc_pkg::FRAC_W;
   localparam int STEPS  = ntc_pkg::FRAC_W;
   localparam int SQ_W   = 2 * MANT_W;

   // Stage A: leading-one position.
   logic                          a_valid_ff;
   ntc_pkg::flags_type            a_flags_ff;
   logic [L-1:0][IN_W-1:0]        a_x_ff;
   logic [L-1:0][TOP_W-1:0]       a_top_ff;
   logic [L-1:0][TOP_W-1:0]       a_top_in;

   // Stage B: mantissa normalized to [1,2).
   logic                          b_valid_ff;
   ntc_pkg::flags_type            b_flags_ff;
   logic [L-1:0][TOP_W-1:0]       b_top_ff;
   logic [L-1:0][MANT_W-1:0]      b_m_ff;
   logic [L-1:0][MANT_W-1:0]      b_m_in;

   // Squaring stages, one fraction bit each.
   logic                          sq_valid_ff [STEPS];
   ntc_pkg::flags_type            sq_flags_ff [STEPS];
   logic [L-1:0][TOP_W-1:0]       sq_top_ff   [STEPS];
   logic [L-1:0][MANT_W-1:0]      sq_m_ff     [STEPS];
   logic [L-1:0][FRAC_W-1:0]      sq_f_ff     [STEPS];
   logic                          sq_valid_in [STEPS];
   ntc_pkg::flags_type            sq_flags_in [STEPS];
   logic [L-1:0][TOP_W-1:0]       sq_top_in   [STEPS];
   logic [L-1:0][MANT_W-1:0]      sq_m_in     [STEPS];
   logic [L-1:0][FRAC_W-1:0]      sq_f_in     [STEPS];

   always_comb begin
      for (int l = 0; l < L; l++) begin
         a_top_in[l] = '0;
         for (int i = 1; i < IN_W; i++) begin
            if (in_x[l][i]) begin
               a_top_in[l] = TOP_W'(i);
            end
         end
      end
   end

   always_comb begin
      logic [IN_W-1:0] norm;
      norm = '0;
      for (int l = 0; l < L; l++) begin
         norm      = a_x_ff[l] << (TOP_W'(IN_W - 1) - a_top_ff[l]);
         b_m_in[l] = norm[IN_W-1 -: MANT_W];
      end
   end

   always_comb begin
      logic [L-1:0][MANT_W-1:0] prev_m;
      logic [L-1:0][FRAC_W-1:0] prev_f;
      logic [SQ_W-1:0]          sq;
      logic [MANT_W:0]          sh;
      prev_m = '0;
      prev_f = '0;
      sq     = '0;
      sh     = '0;
      for (int s = 0; s < STEPS; s++) begin
         if (s == 0) begin
            sq_valid_in[s] = b_valid_ff;
            sq_flags_in[s] = b_flags_ff;
            sq_top_in[s]   = b_top_ff;
            prev_m         = b_m_ff;
            prev_f         = '0;
         end else begin
            sq_valid_in[s] = sq_valid_ff[s-1];
            sq_flags_in[s] = sq_flags_ff[s-1];
            sq_top_in[s]   = sq_top_ff[s-1];
            prev_m         = sq_m_ff[s-1];
            prev_f         = sq_f_ff[s-1];
         end
         for (int l = 0; l < L; l++) begin
            sq = SQ_W'(prev_m[l]) * SQ_W'(prev_m[l]);
            sh = sq[SQ_W-1:FRAC_W];
            // Once the square reaches two, the fraction bit is one and m is halved.
            if (sh[MANT_W]) begin
               sq_m_in[s][l] = sh[MANT_W:1];
            end else begin
               sq_m_in[s][l] = sh[MANT_W-1:0];
            end
            sq_f_in[s][l] = {prev_f[l][FRAC_W-2:0], sh[MANT_W]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         for (int s = 0; s < STEPS; s++) begin
            sq_valid_ff[s] <= 1'b0;
         end
      end else if (advance) begin
         a_valid_ff <= in_valid;
         b_valid_ff <= a_valid_ff;
         for (int s = 0; s < STEPS; s++) begin
            sq_valid_ff[s] <= sq_valid_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         a_flags_ff <= in_flags;
         a_x_ff     <= in_x;
         a_top_ff   <= a_top_in;
         b_flags_ff <= a_flags_ff;
         b_top_ff   <= a_top_ff;
         b_m_ff     <= b_m_in;
         for (int s = 0; s < STEPS; s++) begin
            sq_flags_ff[s] <= sq_flags_in[s];
            sq_top_ff[s]   <= sq_top_in[s];
            sq_m_ff[s]     <= sq_m_in[s];
            sq_f_ff[s]     <= sq_f_in[s];
         end
      end
   end

   always_comb begin
      for (int l = 0; l < L; l++) begin
         out_log[l] = {sq_top_ff[STEPS-1][l], sq_f_ff[STEPS-1][l]};
      end
   end

   assign out_valid = sq_valid_ff[STEPS-1];
   assign out_flags = sq_flags_ff[STEPS-1];

endmodule

/* rtl/ntc_div_pipe.sv */
// Pipelined restoring divider, one quotient bit per stage, for one or more lanes.
// The divisor travels with its beat. Depends on ntc_pkg.
module ntc_div_pipe #(
   parameter int LANES = 1,
   parameter int DW    = ntc_pkg::KELVIN_W
) (
   input  logic clock,
   input  logic reset,
   input  logic advance,
   input  logic in_valid,
   input  logic [LANES-1:0][ntc_pkg::DIV_NUM_W-1:0] in_num,
   input  logic [LANES-1:0][DW-1:0] in_den,
   input  ntc_pkg::flags_type in_flags,
   output logic out_valid,
   output logic [LANES-1:0][ntc_pkg::DIV_NUM_W-1:0] out_quo,
   output ntc_pkg::flags_type out_flags
);

   localparam int NW = ntc_pkg::DIV_NUM_W;

   logic                      valid_ff [NW];
   ntc_pkg::flags_type        flags_ff [NW];
   logic [LANES-1:0][DW-1:0]  rem_ff   [NW];
   logic [LANES-1:0][DW-1:0]  den_ff   [NW];
   logic [LANES-1:0][NW-1:0]  num_ff   [NW];
   logic [LANES-1:0][NW-1:0]  quo_ff   [NW];

   logic                      valid_in [NW];
   ntc_pkg::flags_type        flags_in [NW];
   logic [LANES-1:0][DW-1:0]  rem_in   [NW];
   logic [LANES-1:0][DW-1:0]  den_in   [NW];
   logic [LANES-1:0][NW-1:0]  num_in   [NW];
   logic [LANES-1:0][NW-1:0]  quo_in   [NW];

   always_comb begin
      logic [LANES-1:0][DW-1:0] prev_rem;
      logic [LANES-1:0][NW-1:0] prev_num;
      logic [LANES-1:0][NW-1:0] prev_quo;
      logic [DW:0]              trial;
      logic                     fits;
      prev_rem = '0;
      prev_num = '0;
      prev_quo = '0;
      trial    = '0;
      fits     = 1'b0;
      for (int s = 0; s < NW; s++) begin
         if (s == 0) begin
            valid_in[s] = in_valid;
            flags_in[s] = in_flags;
            den_in[s]   = in_den;
            prev_rem    = '0;
            prev_num    = in_num;
            prev_quo    = '0;
         end else begin
            valid_in[s] = valid_ff[s-1];
            flags_in[s] = flags_ff[s-1];
            den_in[s]   = den_ff[s-1];
            prev_rem    = rem_ff[s-1];
            prev_num    = num_ff[s-1];
            prev_quo    = quo_ff[s-1];
         end
         for (int l = 0; l < LANES; l++) begin
            trial = {prev_rem[l], prev_num[l][NW-1]};
            fits  = (trial >= {1'b0, den_in[s][l]});
            if (fits) begin
               rem_in[s][l] = DW'(trial - {1'b0, den_in[s][l]});
            end else begin
               rem_in[s][l] = trial[DW-1:0];
            end
            num_in[s][l] = {prev_num[l][NW-2:0], 1'b0};
            quo_in[s][l] = {prev_quo[l][NW-2:0], fits};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < NW; s++) begin
            valid_ff[s] <= 1'b0;
         end
      end else if (advance) begin
         for (int s = 0; s < NW; s++) begin
            valid_ff[s] <= valid_in[s];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int s = 0; s < NW; s++) begin
            flags_ff[s] <= flags_in[s];
            rem_ff[s]   <= rem_in[s];
            den_ff[s]   <= den_in[s];
            num_ff[s]   <= num_in[s];
            quo_ff[s]   <= quo_in[s];
         end
      end
   end

   assign out_valid = valid_ff[NW-1];
   assign out_flags = flags_ff[NW-1];
   assign out_quo   = quo_ff[NW-1];

endmodule

/* dv/tb_ntc_beta_temperature_convert.sv */
// Self-checking testbench for the NTC thermistor Beta-equation converter.
// Depends on ntc_pkg and ntc_beta_temperature_convert; predicts each result in fixed point.
`timescale 1ns / 100ps

module tb_ntc_beta_temperature_convert;

   localparam int FULL_SCALE = 4095;
   localparam int LATENCY    = 115;
   localparam int STALL_MAX  = 12;
   localparam int WATCHDOG   = 20000;

   typedef struct packed {
      logic signed [ntc_pkg::TEMP_W-1:0] temp;
      logic out_of_range;
   } reading_type;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_ready;
   logic [ntc_pkg::CODE_W-1:0] req_adc_code = '0;
   logic rsp_valid;
   logic rsp_ready = 0;
   logic signed [ntc_pkg::TEMP_W-1:0] rsp_temp_centi_celsius;
   logic rsp_out_of_range;
   logic csr_wr_en = 0;
   logic [ntc_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [ntc_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   logic [ntc_pkg::OHMS_W-1:0]   pullup_q, nominal_q;
   logic [ntc_pkg::KELVIN_W-1:0] beta_q, t0_q;
   logic [ntc_pkg::CODE_W-1:0]   low_q, high_q;

   reading_type expected_readings[$];
   int  errors = 0;
   int  idle_cycles = 0;
   bit  stimulus_done = 0;

   always #2 clock = ~clock;

   ntc_beta_temperature_convert DUT (.*);

   function automatic logic [63:0] log2_q30(logic [63:0] x);
      int top;
      logic [63:0] m, f;
      logic [127:0] sq;
      top = 63;
      f = 0;
      if (x == 0) x = 1;
      while (top > 0 && x[top] == 1'b0) top--;
      m = (top >= ntc_pkg::FRAC_W) ? x >> (top - ntc_pkg::FRAC_W)
                                   : x << (ntc_pkg::FRAC_W - top);
      for (int i = ntc_pkg::FRAC_W - 1; i >= 0; i--) begin
         sq = m * m;
         m = sq >> ntc_pkg::FRAC_W;
         if (m >= (64'd1 << (ntc_pkg::FRAC_W + 1))) begin
            m = m >> 1;
            f[i] = 1'b1;
         end
      end
      return (64'(top) << ntc_pkg::FRAC_W) | f;
   endfunction

   function automatic reading_type convert_code(logic [ntc_pkg::CODE_W-1:0] c);
      reading_type r;
      logic [63:0] a, b, dmag, lnmag, q, inv0, inv, tk, beta, t0, one;
      logic neg;
      one = 64'd100 << ntc_pkg::FRAC_W;
      r.temp = 0;
      r.out_of_range = 0;
      if (c <= low_q || c >= high_q || c >= FULL_SCALE) begin
         r.out_of_range = 1;
         return r;
      end
      if (c == 0) begin
         r.temp = ntc_pkg::TEMP_MAX;
         return r;
      end
      a = log2_q30(64'(pullup_q == 0 ? 1 : pullup_q) * c);
      b = log2_q30(FULL_SCALE - c) + log2_q30(64'(nominal_q == 0 ? 1 : nominal_q));
      neg = a < b;
      dmag = neg ? b - a : a - b;
      lnmag = (dmag * 64'd46516320 + (64'd1 << 25)) >> 26;
      beta = beta_q == 0 ? 1 : beta_q;
      q = (lnmag + beta / 2) / beta;
      t0 = t0_q == 0 ? 1 : t0_q;
      inv0 = (one + t0 / 2) / t0;
      if (neg) begin
         if (q >= inv0) begin
            r.temp = ntc_pkg::TEMP_MAX;
            return r;
         end
         inv = inv0 - q;
      end else begin
         inv = inv0 + q;
      end
      tk = (one + inv / 2) / inv;
      if (tk > 92850) r.temp = ntc_pkg::TEMP_MAX;
      else r.temp = ntc_pkg::TEMP_W'(64'(tk) - 27315);
      return r;
   endfunction

   task automatic write_csr(ntc_pkg::csr_index_type idx,
                            logic [ntc_pkg::CSR_DATA_W-1:0] value);
      csr_wr_en <= 1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      case (idx)
         ntc_pkg::CSR_PULLUP_OHMS:  pullup_q  = value[ntc_pkg::OHMS_W-1:0];
         ntc_pkg::CSR_NOMINAL_OHMS: nominal_q = value[ntc_pkg::OHMS_W-1:0];
         ntc_pkg::CSR_BETA_KELVIN:  beta_q    = value[ntc_pkg::KELVIN_W-1:0];
         ntc_pkg::CSR_NOMINAL_CK:   t0_q      = value[ntc_pkg::KELVIN_W-1:0];
         ntc_pkg::CSR_LOW_LIMIT:    low_q     = value[ntc_pkg::CODE_W-1:0];
         ntc_pkg::CSR_HIGH_LIMIT:   high_q    = value[ntc_pkg::CODE_W-1:0];
         default: ;
      endcase
   endtask

   // Valid stays high between back-to-back beats; it drops only for a gap or a drain.
   task automatic send_code(logic [ntc_pkg::CODE_W-1:0] c, bit gaps);
      int gap;
      gap = gaps ? $urandom_range(STALL_MAX) : 0;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_adc_code <= c;
      do @(posedge clock); while (!req_ready);
      expected_readings.push_back(convert_code(c));
   endtask

   // Registers only change once the pipeline has drained.
   task automatic drain;
      req_valid <= 0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
   endtask

   task automatic load_setting(logic [23:0] pu, logic [23:0] nom, logic [15:0] beta,
                               logic [15:0] t0, logic [11:0] lo, logic [11:0] hi);
      drain();
      write_csr(ntc_pkg::CSR_PULLUP_OHMS, pu);
      write_csr(ntc_pkg::CSR_NOMINAL_OHMS, nom);
      write_csr(ntc_pkg::CSR_BETA_KELVIN, 24'(beta));
      write_csr(ntc_pkg::CSR_NOMINAL_CK, 24'(t0));
      write_csr(ntc_pkg::CSR_LOW_LIMIT, 24'(lo));
      write_csr(ntc_pkg::CSR_HIGH_LIMIT, 24'(hi));
      csr_wr_en <= 0;
   endtask

   task automatic test_directed_codes;
      logic [ntc_pkg::CODE_W-1:0] codes[] = '{0, 1, 49, 50, 51, 2048, 3999, 4000, 4094,
                                              4095, 12'haaa, 12'h555, 12'hfff, 12'h800,
                                              12'h7ff};
      foreach (codes[i]) send_code(codes[i], 0);
      // Open limits pass every code from 1 to 4094 into the conversion.
      load_setting(100000, 10000, 3950, 29815, 0, 4095);
      foreach (codes[i]) send_code(codes[i], 1);
   endtask

   task automatic test_register_extremes;
      load_setting(0, 0, 0, 0, 0, 4095);
      repeat (40) send_code($urandom_range(4095), 1);
      load_setting(24'hffffff, 1, 1, 16'hffff, 0, 4095);
      repeat (40) send_code($urandom_range(4095), 1);
      load_setting(1, 24'hffffff, 16'hffff, 1, 0, 4095);
      repeat (40) send_code($urandom_range(4095), 1);
      // Crossed limits reject every code.
      load_setting(100000, 10000, 3950, 29815, 4095, 0);
      repeat (20) send_code($urandom_range(4095), 1);
   endtask

   task automatic test_random_settings;
      for (int p = 0; p < 6; p++) begin
         load_setting($urandom_range(24'hffffff), $urandom_range(24'hffffff),
                      $urandom_range(16'hffff), $urandom_range(16'hffff),
                      $urandom_range(200), $urandom_range(4095, 3800));
         repeat (80) send_code($urandom_range(4095), $urandom_range(3) != 0);
      end
      // Realistic thermistor settings carry most of the traffic.
      load_setting(100000, 10000, 3950, 29815, 50, 4000);
      repeat (600) send_code($urandom_range(4095), $urandom_range(3) != 0);
      load_setting(10000, 10000, 3435, 29815, 10, 4085);
      repeat (450) send_code($urandom_range(4095), $urandom_range(3) != 0);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_readings.size() == 0) begin
            $error("unexpected result beat temp=%0d", rsp_temp_centi_celsius);
            errors++;
         end else begin
            reading_type e;
            e = expected_readings.pop_front();
            if (e.temp !== rsp_temp_centi_celsius) begin
               $error("temp_centi_celsius expected %0d actual %0d", e.temp,
                      rsp_temp_centi_celsius);
               errors++;
            end
            if (e.out_of_range !== rsp_out_of_range) begin
               $error("out_of_range expected %0d actual %0d", e.out_of_range,
                      rsp_out_of_range);
               errors++;
            end
         end
      end
   end

   // Receiver stall: a random wait before each beat, with some stall-free stretches.
   initial begin
      int wait_cycles;
      @(negedge reset);
      forever begin
         wait_cycles = ($urandom_range(7) == 0) ? 0 : $urandom_range(STALL_MAX);
         if (wait_cycles > 0) begin
            rsp_ready <= 0;
            repeat (wait_cycles) @(posedge clock);
         end
         rsp_ready <= 1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || reset || stimulus_done)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      pullup_q = ntc_pkg::PULLUP_RESET;
      nominal_q = ntc_pkg::NOMINAL_RESET;
      beta_q = ntc_pkg::BETA_RESET;
      t0_q = ntc_pkg::T0_RESET;
      low_q = ntc_pkg::LOW_RESET;
      high_q = ntc_pkg::HIGH_RESET;
      repeat (10) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed_codes();
      test_register_extremes();
      test_random_settings();
      drain();
      stimulus_done = 1;
      if (errors == 0 && expected_readings.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
